// ----- rtl/scbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Brace matcher package
// Shared constants, codes, beat types and helpers of the brace matcher.
// ----------------------------------------------------------------------------
package scbm_pkg;

  // Default widths of the internal nesting depth and byte index counters.
  localparam int unsigned DefDepthBits = 8;
  localparam int unsigned DefIndexBits = 16;

  // Widths of the beat fields.
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned DepthWidth  = 8;

  // Character codes the scanner looks for.
  localparam logic [ByteWidth-1:0] ChOpen   = 8'd123;
  localparam logic [ByteWidth-1:0] ChClose  = 8'd125;
  localparam logic [ByteWidth-1:0] ChSlash  = 8'd47;
  localparam logic [ByteWidth-1:0] ChStar   = 8'd42;
  localparam logic [ByteWidth-1:0] ChDquote = 8'd34;
  localparam logic [ByteWidth-1:0] ChSquote = 8'd39;
  localparam logic [ByteWidth-1:0] ChBquote = 8'd96;
  localparam logic [ByteWidth-1:0] ChBslash = 8'd92;
  localparam logic [ByteWidth-1:0] ChNl     = 8'd10;

  typedef enum logic [1:0] {
    ST_SCAN    = 2'd0,
    ST_MATCH   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    QK_NONE   = 2'd0,
    QK_DOUBLE = 2'd1,
    QK_SINGLE = 2'd2,
    QK_BACK   = 2'd3
  } quote_e;

  typedef struct packed {
    logic [ByteWidth-1:0] text_byte;
    logic                 first;
    logic                 last;
  } scbm_item_t;

  typedef struct packed {
    status_e                status;
    logic [OffsetWidth-1:0] offset;
    logic [DepthWidth-1:0]  depth;
  } scbm_result_t;

  // Maps a byte to the kind of quote it is, or none.
  function automatic quote_e quote_code(input logic [ByteWidth-1:0] c);
    quote_e q;
    q = QK_NONE;
    if (c == ChDquote) begin
      q = QK_DOUBLE;
    end else if (c == ChSquote) begin
      q = QK_SINGLE;
    end else if (c == ChBquote) begin
      q = QK_BACK;
    end
    return q;
  endfunction

endpackage

// ----- rtl/scbm_if.sv -----
// ----------------------------------------------------------------------------
// Brace matcher stream interfaces
// Valid/ready channels for text bytes in and per-byte results out.
// ----------------------------------------------------------------------------
interface scbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first;
  logic       last;

  modport source (output valid, output text_byte, output first, output last, input ready);
  modport sink   (input valid, input text_byte, input first, input last, output ready);
endinterface

interface scbm_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [15:0]       offset;
  logic [7:0]        depth;

  modport source (output valid, output status, output offset, output depth, input ready);
  modport sink   (input valid, input status, input offset, input depth, output ready);
endinterface

// ----- rtl/string_comment_aware_brace_matcher.sv -----
// ----------------------------------------------------------------------------
// String and comment aware brace matcher
// Finds the closing brace that matches an opening brace in a byte stream.
// ----------------------------------------------------------------------------
// The block takes the text that follows an opening brace one byte per beat
// and returns one result beat for every byte: a status (scanning, this byte
// is the match, no match by the last byte, or ignored after a match), the
// byte's offset from the first byte and the nesting depth after it, both
// saturating. Braces inside line comments, block comments and strings in
// double, single or back quotes are not counted; a backslash just before a
// quote keeps the string open. A byte marked first restarts the scan. The
// block takes one byte every cycle while the result side takes beats. An
// accepted byte sits in the input register while the scan core works on it;
// when the result register is free, the core updates its state and the
// result register captures the beat at the same edge. The only loop is the
// state update in the scan core, so bytes follow each other with no gaps
// while the result side keeps taking beats. When the result side stalls,
// the result register and then the input register each hold one beat, and
// input ready stays low until the result side takes a beat.
// ----------------------------------------------------------------------------
module string_comment_aware_brace_matcher #(
  parameter int unsigned DEPTH_BITS = scbm_pkg::DefDepthBits,
  parameter int unsigned INDEX_BITS = scbm_pkg::DefIndexBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scbm_in_if.sink    in_i,
  scbm_out_if.source out_o
);
  import scbm_pkg::*;

  // Input register stage.
  logic         s1_valid_q;
  scbm_item_t   s1_item_q;

  // Result register stage.
  logic         out_valid_q;
  scbm_result_t out_res_q;

  scbm_result_t core_res;
  logic         out_free;
  logic         advance;
  logic         in_fire;

  // The result register can take a beat when empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  scbm_scan_core #(
    .DEPTH_BITS (DEPTH_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.text_byte <= in_i.text_byte;
      s1_item_q.first     <= in_i.first;
      s1_item_q.last      <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_res_q.status;
  assign out_o.offset = out_res_q.offset;
  assign out_o.depth  = out_res_q.depth;

  // A match or an ignored byte always reports depth zero.
  a_depth_zero_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.status == ST_MATCH || out_res_q.status == ST_IGNORED))
      |-> (out_res_q.depth == '0))
    else $error("nonzero depth on match or ignored byte");

  // A byte held in the input register while the result side is blocked stays put.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register lost a byte under stall");

  // Every accepted byte lands in the input register.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted byte not captured");

endmodule

// ----- rtl/scbm_scan_core.sv -----
// ----------------------------------------------------------------------------
// Brace matcher scan core
// Holds the lexical state and computes one byte's result and state update.
// ----------------------------------------------------------------------------
module scbm_scan_core #(
  parameter int unsigned DEPTH_BITS = scbm_pkg::DefDepthBits,
  parameter int unsigned INDEX_BITS = scbm_pkg::DefIndexBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  scbm_pkg::scbm_item_t  item_i,
  output scbm_pkg::scbm_result_t result_o
);
  import scbm_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
  localparam logic [INDEX_BITS-1:0] IndexMax = {INDEX_BITS{1'b1}};
  localparam int unsigned DepthExtW = (DEPTH_BITS > DepthWidth) ? DEPTH_BITS : DepthWidth;
  localparam int unsigned IndexExtW = (INDEX_BITS > OffsetWidth) ? INDEX_BITS : OffsetWidth;

  logic [DEPTH_BITS-1:0] depth_q, depth_d, depth_e, depth_dec, depth_out;
  logic                  str_q, str_d, str_e;
  quote_e                qk_q, qk_d, qk_e;
  logic                  lc_q, lc_d, lc_e;
  logic                  bc_q, bc_d, bc_e;
  logic [ByteWidth-1:0]  prev_q, prev_d, prev_e;
  logic                  cons_q, cons_d, cons_e;
  logic [INDEX_BITS-1:0] idx_q, idx_d, idx_e;
  logic                  match_q, match_d, match_e;

  logic [ByteWidth-1:0]  c;
  quote_e                q;
  logic                  plain;
  logic                  used;
  status_e               status;
  logic [DepthExtW-1:0]  depth_ext;
  logic [IndexExtW-1:0]  idx_ext;

  assign c = item_i.text_byte;
  assign q = quote_code(c);

  always_comb begin
    // A first mark restarts the scan before this byte is looked at.
    depth_e = item_i.first ? DEPTH_BITS'(1) : depth_q;
    str_e   = item_i.first ? 1'b0 : str_q;
    qk_e    = item_i.first ? QK_NONE : qk_q;
    lc_e    = item_i.first ? 1'b0 : lc_q;
    bc_e    = item_i.first ? 1'b0 : bc_q;
    prev_e  = item_i.first ? ChOpen : prev_q;
    cons_e  = item_i.first ? 1'b0 : cons_q;
    idx_e   = item_i.first ? '0 : idx_q;
    match_e = item_i.first ? 1'b0 : match_q;

    depth_d = depth_e;
    str_d   = str_e;
    qk_d    = qk_e;
    lc_d    = lc_e;
    bc_d    = bc_e;
    prev_d  = prev_e;
    cons_d  = cons_e;
    match_d = match_e;
    idx_d   = (idx_e != IndexMax) ? idx_e + 1'b1 : idx_e;

    plain     = !lc_e && !bc_e;
    used      = 1'b0;
    status    = ST_SCAN;
    depth_out = '0;
    depth_dec = (depth_e != '0) ? depth_e - 1'b1 : depth_e;

    if (match_e) begin
      status = ST_IGNORED;
    end else begin
      // Two-byte comment markers; a byte that closed a marker cannot open one.
      if (!str_e) begin
        if (plain && !cons_e && prev_e == ChSlash && c == ChSlash) begin
          lc_d = 1'b1;
          used = 1'b1;
        end else if (plain && !cons_e && prev_e == ChSlash && c == ChStar) begin
          bc_d = 1'b1;
          used = 1'b1;
        end else if (bc_e && !cons_e && prev_e == ChStar && c == ChSlash) begin
          bc_d = 1'b0;
          used = 1'b1;
        end else if (lc_e && c == ChNl) begin
          lc_d = 1'b0;
        end
      end
      if (!used) begin
        if (!lc_d && !bc_d) begin
          if (!str_e && q != QK_NONE) begin
            str_d = 1'b1;
            qk_d  = q;
          end else if (str_e && q != QK_NONE && q == qk_e && prev_e != ChBslash) begin
            str_d = 1'b0;
            qk_d  = QK_NONE;
          end
        end
        if (!str_d && !lc_d && !bc_d) begin
          if (c == ChOpen) begin
            if (depth_e != DepthMax) begin
              depth_d = depth_e + 1'b1;
            end
          end else if (c == ChClose) begin
            depth_d = depth_dec;
            if (depth_dec == '0) begin
              match_d = 1'b1;
              status  = ST_MATCH;
            end
          end
        end
      end
      prev_d = c;
      cons_d = used;
      if (status != ST_MATCH && item_i.last) begin
        status = ST_NOMATCH;
      end
      depth_out = depth_d;
    end
  end

  assign depth_ext = DepthExtW'(depth_out);
  assign idx_ext   = IndexExtW'(idx_e);

  always_comb begin
    result_o.status = status;
    result_o.depth  = (depth_ext > DepthExtW'({DepthWidth{1'b1}})) ?
                      {DepthWidth{1'b1}} : depth_ext[DepthWidth-1:0];
    result_o.offset = (idx_ext > IndexExtW'({OffsetWidth{1'b1}})) ?
                      {OffsetWidth{1'b1}} : idx_ext[OffsetWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_BITS'(1);
      str_q   <= 1'b0;
      qk_q    <= QK_NONE;
      lc_q    <= 1'b0;
      bc_q    <= 1'b0;
      prev_q  <= ChOpen;
      cons_q  <= 1'b0;
      idx_q   <= '0;
      match_q <= 1'b0;
    end else if (step_i) begin
      depth_q <= depth_d;
      str_q   <= str_d;
      qk_q    <= qk_d;
      lc_q    <= lc_d;
      bc_q    <= bc_d;
      prev_q  <= prev_d;
      cons_q  <= cons_d;
      idx_q   <= idx_d;
      match_q <= match_d;
    end
  end

  // A string and a comment are never open at the same time.
  a_str_excl_comment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    str_q |-> (!lc_q && !bc_q))
    else $error("string and comment open together");

  // Once matched, the depth has reached zero and stays there.
  a_match_depth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q |-> (depth_q == '0))
    else $error("matched with nonzero depth");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brace matcher testbench
// Drives byte streams into the string and comment aware brace matcher and
// checks every result beat against its typed row or the bench's scan model.
// ----------------------------------------------------------------------------
// Flow of the run:
//   1. A short directed pass walks a stimulus table. It covers the reset
//      state with no first mark, line comments, block comments with a shared
//      star, escaped quotes, all three quote kinds, bytes after a match, the
//      extreme byte values and a match on the last byte.
//   2. A depth run pushes the nesting depth into saturation and back down.
//   3. Random texts are built from tokens (braces, comments, strings,
//      escapes, noise) and framed with first and last marks. A share of them
//      carry broken framing.
// The sender works in bursts with gaps. The receiver stalls on its own
// pattern, holds off once for a long stretch, and the sender drains the
// block after the directed table and once mid-stream before going on.
// ----------------------------------------------------------------------------
module tb;
  import scbm_pkg::*;

  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomBytes = 1400;
  localparam int unsigned DepthPushes = 300;
  localparam int unsigned DepthPops   = 260;
  localparam int unsigned DrainLimit  = 100000;
  localparam int unsigned TailCycles  = 10;

  localparam logic [DefDepthBits-1:0] DepthMax = '1;
  localparam logic [DefIndexBits-1:0] IndexMax = '1;

  // One row of the directed table. Where typed is set, the expected result
  // is the one written in the row; otherwise the scan model supplies it.
  typedef struct packed {
    logic [ByteWidth-1:0] text_byte;
    logic                 first;
    logic                 last;
    logic                 typed;
    scbm_result_t         res;
  } stim_row_t;

  localparam scbm_result_t NoRes = '{ST_SCAN, 16'd0, 8'd0};
  localparam int unsigned  NumRows = 26;

  localparam stim_row_t DirRows [NumRows] = '{
    // Reset state behaves as a fresh start: a bare closing brace matches.
    '{ChClose,  1'b0, 1'b0, 1'b1, '{ST_MATCH,   16'd0, 8'd0}},
    // After the match bytes are ignored but the offset keeps counting.
    '{8'hFF,    1'b0, 1'b0, 1'b1, '{ST_IGNORED, 16'd1, 8'd0}},
    // A first mark restarts the scan; an open brace nests one deeper.
    '{ChOpen,   1'b1, 1'b0, 1'b1, '{ST_SCAN,    16'd0, 8'd2}},
    '{ChClose,  1'b0, 1'b0, 1'b0, NoRes},
    // Line comment: the closing brace inside it does not count.
    '{ChSlash,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChSlash,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChClose,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChNl,     1'b0, 1'b0, 1'b0, NoRes},
    // Block comment where the opening star must not also close it.
    '{ChSlash,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChStar,   1'b0, 1'b0, 1'b0, NoRes},
    '{ChSlash,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChClose,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChStar,   1'b0, 1'b0, 1'b0, NoRes},
    '{ChSlash,  1'b0, 1'b0, 1'b0, NoRes},
    // Double quoted string with an escaped quote and a brace inside.
    '{ChDquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChBslash, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChDquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChClose,  1'b0, 1'b0, 1'b0, NoRes},
    '{ChDquote, 1'b0, 1'b0, 1'b0, NoRes},
    // A back quote does not close a single quoted string.
    '{ChSquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChBquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChSquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChBquote, 1'b0, 1'b0, 1'b0, NoRes},
    '{ChBquote, 1'b0, 1'b0, 1'b0, NoRes},
    // Last byte with the brace still open reports no match.
    '{8'h00,    1'b0, 1'b1, 1'b0, NoRes},
    // A match on the last byte reports the match, not the miss.
    '{ChClose,  1'b1, 1'b1, 1'b1, '{ST_MATCH,   16'd0, 8'd0}}
  };

  logic clk_i;
  logic rst_ni;

  scbm_in_if  in_bus ();
  scbm_out_if out_bus ();

  string_comment_aware_brace_matcher dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Scan model state. It mirrors what the block keeps between bytes.
  // --------------------------------------------------------------------------
  logic [DefDepthBits-1:0] nest;
  logic                    in_str;
  quote_e                  open_quote;
  logic                    in_line;
  logic                    in_block;
  logic [ByteWidth-1:0]    prev_byte;
  logic                    prev_used;
  logic [DefIndexBits-1:0] byte_idx;
  logic                    found;

  scbm_result_t            pending_q [$];
  logic [ByteWidth-1:0]    text_q [$];

  // The typed expectation travels next to the beat it belongs to, so it is
  // stable at the edge that accepts that beat.
  logic                    typed_v;
  scbm_result_t            typed_r;

  int unsigned errors;
  int unsigned n_bytes;
  int unsigned n_results;
  int unsigned n_match;
  int unsigned n_nomatch;
  int unsigned n_ignored;
  int unsigned max_depth;
  int unsigned max_offset;
  int unsigned burst_left;
  logic        hold_req;

  function automatic void restart_scan();
    nest       = DefDepthBits'(1);
    in_str     = 1'b0;
    open_quote = QK_NONE;
    in_line    = 1'b0;
    in_block   = 1'b0;
    prev_byte  = ChOpen;
    prev_used  = 1'b0;
    byte_idx   = '0;
    found      = 1'b0;
  endfunction

  function automatic quote_e quote_kind_of(input logic [ByteWidth-1:0] c);
    case (c)
      ChDquote: return QK_DOUBLE;
      ChSquote: return QK_SINGLE;
      ChBquote: return QK_BACK;
      default:  return QK_NONE;
    endcase
  endfunction

  // Advances the scan model by one byte and returns the result it causes.
  function automatic scbm_result_t scan_byte(input scbm_item_t it);
    scbm_result_t         r;
    logic [ByteWidth-1:0] c;
    logic                 used;
    logic                 plain;
    logic                 pfree;
    quote_e               q;
    c        = it.text_byte;
    used     = 1'b0;
    r.status = ST_SCAN;
    if (it.first) begin
      restart_scan();
    end
    r.offset = byte_idx;
    if (byte_idx != IndexMax) begin
      byte_idx = byte_idx + 1'b1;
    end
    if (found) begin
      // Once matched, everything but the offset is frozen.
      r.status = ST_IGNORED;
      r.depth  = '0;
    end else begin
      pfree = !prev_used;
      // Two-byte markers only open or close outside strings, and a byte
      // that already ended one marker cannot start the next.
      if (!in_str) begin
        plain = !in_line && !in_block;
        if (plain && pfree && prev_byte == ChSlash && c == ChSlash) begin
          in_line = 1'b1;
          used    = 1'b1;
        end else if (plain && pfree && prev_byte == ChSlash && c == ChStar) begin
          in_block = 1'b1;
          used     = 1'b1;
        end else if (in_block && pfree && prev_byte == ChStar && c == ChSlash) begin
          in_block = 1'b0;
          used     = 1'b1;
        end else if (in_line && c == ChNl) begin
          in_line = 1'b0;
        end
      end
      if (!used) begin
        if (!in_line && !in_block) begin
          q = quote_kind_of(c);
          if (!in_str && q != QK_NONE) begin
            in_str     = 1'b1;
            open_quote = q;
          end else if (in_str && q != QK_NONE && q == open_quote && prev_byte != ChBslash) begin
            in_str     = 1'b0;
            open_quote = QK_NONE;
          end
        end
        if (!in_str && !in_line && !in_block) begin
          if (c == ChOpen) begin
            if (nest < DepthMax) begin
              nest = nest + 1'b1;
            end
          end else if (c == ChClose) begin
            if (nest != 0) begin
              nest = nest - 1'b1;
            end
            if (nest == 0) begin
              found    = 1'b1;
              r.status = ST_MATCH;
            end
          end
        end
      end
      prev_byte = c;
      prev_used = used;
      if (r.status != ST_MATCH && it.last) begin
        r.status = ST_NOMATCH;
      end
      r.depth = nest;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: every accepted input beat is run through the scan model, every
  // accepted result beat is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    scbm_item_t   it;
    scbm_result_t p;
    scbm_result_t want;
    scbm_result_t got;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        it.text_byte = in_bus.text_byte;
        it.first     = in_bus.first;
        it.last      = in_bus.last;
        p = scan_byte(it);
        n_bytes++;
        pending_q.insert(pending_q.size(), typed_v ? typed_r : p);
      end
      if (out_bus.valid && out_bus.ready) begin
        got.status = status_e'(out_bus.status);
        got.offset = out_bus.offset;
        got.depth  = out_bus.depth;
        n_results++;
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: status %0d offset %0d depth %0d",
                   $time, got.status, got.offset, got.depth);
        end else begin
          want = pending_q.pop_front();
          if (got.status != want.status) begin
            errors++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
          end
          if (got.offset != want.offset) begin
            errors++;
            $display("%0t: offset expected %0d, actual %0d", $time, want.offset, got.offset);
          end
          if (got.depth != want.depth) begin
            errors++;
            $display("%0t: depth expected %0d, actual %0d", $time, want.depth, got.depth);
          end
        end
        case (got.status)
          ST_MATCH:   n_match++;
          ST_NOMATCH: n_nomatch++;
          ST_IGNORED: n_ignored++;
          default:    ;
        endcase
        if (got.depth > max_depth) begin
          max_depth = got.depth;
        end
        if (got.offset > max_offset) begin
          max_offset = got.offset;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns after random stretches and
  // honors a request for one long hold-off, counted here in its own loop.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    mode          = 0;
    left          = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= (left % 4) != 0;
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers.
  // --------------------------------------------------------------------------

  // Offers one beat and returns at the edge that accepts it. Between bursts
  // valid drops for a random gap; inside a burst it stays high.
  task automatic send_beat(input logic [ByteWidth-1:0] b, input logic f, input logic l,
                           input logic has_typed, input scbm_result_t tr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_bus.valid     <= 1'b1;
    in_bus.text_byte <= b;
    in_bus.first     <= f;
    in_bus.last      <= l;
    typed_v          <= has_typed;
    typed_r          <= tr;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
    burst_left = $urandom_range(1, 32);
  endtask

  // Appends one byte to the text being built.
  function automatic void add_char(input logic [ByteWidth-1:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic logic [ByteWidth-1:0] filler_char();
    case ($urandom_range(0, 11))
      0:       return ChOpen;
      1:       return ChClose;
      2:       return ChSlash;
      3:       return ChStar;
      4:       return ChDquote;
      5:       return ChSquote;
      6:       return ChBquote;
      7:       return ChBslash;
      8:       return ChNl;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic logic [ByteWidth-1:0] any_quote();
    case ($urandom_range(0, 2))
      0:       return ChDquote;
      1:       return ChSquote;
      default: return ChBquote;
    endcase
  endfunction

  // Builds one random text from tokens. Most tokens are well formed (paired
  // comment markers, closed strings); some are left open or are plain noise.
  task automatic make_text();
    int unsigned          n_tok;
    int unsigned          sel;
    logic [ByteWidth-1:0] qc;
    text_q.delete();
    n_tok = $urandom_range(1, 20);
    repeat (n_tok) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        add_char(ChOpen);
      end else if (sel < 30) begin
        add_char(ChClose);
      end else if (sel < 40) begin
        add_char(8'($urandom_range(97, 122)));
      end else if (sel < 48) begin
        add_char(ChSlash);
        add_char(ChSlash);
        repeat ($urandom_range(0, 6)) add_char(filler_char());
        if ($urandom_range(0, 3) != 0) begin
          add_char(ChNl);
        end
      end else if (sel < 56) begin
        add_char(ChSlash);
        add_char(ChStar);
        repeat ($urandom_range(0, 6)) add_char(filler_char());
        if ($urandom_range(0, 3) != 0) begin
          add_char(ChStar);
          add_char(ChSlash);
        end
      end else if (sel < 72) begin
        qc = any_quote();
        add_char(qc);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_char(ChBslash);
            add_char(qc);
          end else begin
            add_char(filler_char());
          end
        end
        if ($urandom_range(0, 5) != 0) begin
          add_char(qc);
        end
      end else if (sel < 85) begin
        add_char(filler_char());
      end else begin
        add_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : main
    int unsigned sent;
    int unsigned waited;
    logic        noisy;
    logic        f;
    logic        l;

    errors     = 0;
    n_bytes    = 0;
    n_results  = 0;
    n_match    = 0;
    n_nomatch  = 0;
    n_ignored  = 0;
    max_depth  = 0;
    max_offset = 0;
    burst_left = 0;
    hold_req   = 1'b0;
    typed_v    = 1'b0;
    typed_r    = NoRes;
    restart_scan();

    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.text_byte = '0;
    in_bus.first     = 1'b0;
    in_bus.last      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int i = 0; i < NumRows; i++) begin
      send_beat(DirRows[i].text_byte, DirRows[i].first, DirRows[i].last,
                DirRows[i].typed, DirRows[i].res);
    end
    drain();

    // Depth saturation: push far past the ceiling, then pop back to a match
    // and a few ignored bytes beyond it.
    for (int i = 0; i < DepthPushes; i++) begin
      send_beat(ChOpen, i == 0, 1'b0, 1'b0, NoRes);
    end
    for (int i = 0; i < DepthPops; i++) begin
      send_beat(ChClose, 1'b0, i == DepthPops - 1, 1'b0, NoRes);
    end

    // Random texts.
    sent = 0;
    while (sent < RandomBytes) begin
      make_text();
      noisy = ($urandom_range(0, 6) == 0);
      for (int k = 0; k < text_q.size(); k++) begin
        if (noisy) begin
          f = ($urandom_range(0, 19) == 0);
          l = ($urandom_range(0, 19) == 0);
        end else begin
          f = (k == 0);
          l = (k == text_q.size() - 1);
        end
        send_beat(text_q[k], f, l, 1'b0, NoRes);
        sent++;
        // Long receiver hold-off while bytes keep coming, so that the block
        // fills up and pushes back on its input.
        if (sent == 600) begin
          hold_req = 1'b1;
        end
        // One full drain in the middle of the random stream.
        if (sent == 1100) begin
          drain();
        end
      end
    end

    // Wind down: stop offering, wait for the last results, then wait out a
    // tail so that a stray beat would still be seen.
    in_bus.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending_q.size() != 0 && waited < DrainLimit);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_q.size());
    end

    $display("Scanned %0d bytes in %0d result beats: %0d matches, %0d unmatched ends, %0d ignored.",
             n_bytes, n_results, n_match, n_nomatch, n_ignored);
    $display("Deepest nesting reported %0d, highest offset reported %0d, %0d mismatches.",
             max_depth, max_offset, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/scbm_pkg.sv
rtl/scbm_if.sv
rtl/scbm_scan_core.sv
rtl/string_comment_aware_brace_matcher.sv
verif/tb.sv
